>>> rtl/svpwm_duty_calculator_macros.svh
// assertion macros for the svpwm rtl
`ifndef SVPWM_DUTY_CALCULATOR_MACROS_SVH
`define SVPWM_DUTY_CALCULATOR_MACROS_SVH

// implication checked on every clock edge outside reset
`define SVPWM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("svpwm implication check failed");

// invariant checked on every clock edge outside reset
`define SVPWM_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("svpwm invariant check failed");

`endif

>>> rtl/svpwm_pkg.sv
// shared constants, types and helpers of the svpwm duty calculator
`default_nettype none

package svpwm_pkg;

    localparam int FRAC_BITS = 12;

    // fixed-point constants, rounded to nearest
    localparam int Q_ONE        = 1 << FRAC_BITS;
    localparam int Q_HALF       = Q_ONE / 2;
    localparam int Q_PI         = 12868;
    localparam int Q_PI_DIV2    = 6434;
    localparam int Q_PI_DIV3    = 4289;
    localparam int Q_2PI        = 25736;
    localparam int Q_SQRT3      = 7094;
    localparam int Q_SQRT3_DIV3 = 2365;

    // reciprocals for truncating division by 6 and by 120
    localparam int RECIP6      = 43691;
    localparam int RECIP6_SH   = 18;
    localparam int RECIP120    = 34953;
    localparam int RECIP120_SH = 22;

    localparam int SUPPLY_RESET = 49152;
    localparam int PERIOD_RESET = 1000;

    localparam int ANG_W  = 15;
    localparam int SIN_W  = 14;
    localparam int SQ_W   = 26;
    localparam int ROOT_W = 19;
    localparam int UREF_W = 12;
    localparam int SUP_W  = 18;
    localparam int PER_W  = 16;

    // register select on paddr[2]
    localparam logic REG_SUPPLY = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef logic [ANG_W-1:0]        angle_t;
    typedef logic signed [SIN_W-1:0] sine_t;

    typedef enum logic [2:0] {
        SECTOR_NONE = 3'd0,
        SECTOR_1    = 3'd1,
        SECTOR_2    = 3'd2,
        SECTOR_3    = 3'd3,
        SECTOR_4    = 3'd4,
        SECTOR_5    = 3'd5,
        SECTOR_6    = 3'd6,
        SECTOR_WRAP = 3'd7
    } sector_t;

    // v is a non-negative angle below 6*pi, result in [0, 2pi)
    function automatic angle_t wrap_angle(input logic [16:0] v);
        logic [16:0] r;
        r = v;
        if (r >= 17'(2 * Q_2PI)) begin
            r = r - 17'(2 * Q_2PI);
        end
        if (r >= 17'(Q_2PI)) begin
            r = r - 17'(Q_2PI);
        end
        return angle_t'(r);
    endfunction

endpackage

`default_nettype wire

>>> rtl/svpwm_sin.sv
// five-stage pipelined taylor sine over a wrapped angle
`default_nettype none

module svpwm_sin (
    input  logic                 aclk,
    input  logic                 en,
    input  svpwm_pkg::angle_t    x,
    output svpwm_pkg::sine_t     s
);

    // stage 1: fold and square
    logic signed [15:0] xw;
    logic signed [13:0] xf;
    logic signed [27:0] p2;
    logic signed [13:0] xf1_reg;
    logic [13:0]        x2_1_reg;

    // stage 2: cube
    logic signed [28:0] p3;
    logic signed [13:0] xf2_reg;
    logic [13:0]        x2_2_reg;
    logic signed [15:0] x3_2_reg;

    // stage 3: fifth power and divide by 6
    logic signed [30:0] p5;
    logic [14:0]        abs3;
    logic signed [13:0] xf3_reg;
    logic               neg3_3_reg;
    logic [30:0]        q6_3_reg;
    logic signed [16:0] x5_3_reg;

    // stage 4: divide by 120
    logic [15:0]        abs5;
    logic signed [13:0] xf4_reg;
    logic               neg3_4_reg;
    logic               neg5_4_reg;
    logic [11:0]        d6_4_reg;
    logic [31:0]        q120_4_reg;

    // stage 5: sum and clamp
    logic [8:0]         d120;
    logic signed [15:0] d6s;
    logic signed [15:0] d120s;
    logic signed [15:0] acc;
    logic signed [13:0] s_reg;

    always_comb begin
        xw = $signed({1'b0, x});
        if (xw > 16'(svpwm_pkg::Q_PI)) begin
            xw = xw - 16'(svpwm_pkg::Q_2PI);
        end
        if (xw > 16'(svpwm_pkg::Q_PI_DIV2)) begin
            xw = 16'(svpwm_pkg::Q_PI) - xw;
        end else if (xw < -16'(svpwm_pkg::Q_PI_DIV2)) begin
            xw = -16'(svpwm_pkg::Q_PI) - xw;
        end
        xf = 14'(xw);
        p2 = xf * xf;
    end

    always_comb begin
        p3 = xf1_reg * $signed({1'b0, x2_1_reg});
    end

    always_comb begin
        p5   = x3_2_reg * $signed({1'b0, x2_2_reg});
        abs3 = x3_2_reg[15] ? 15'(-x3_2_reg) : 15'(x3_2_reg);
    end

    always_comb begin
        abs5 = x5_3_reg[16] ? 16'(-x5_3_reg) : 16'(x5_3_reg);
    end

    always_comb begin
        d120  = 9'(q120_4_reg >> svpwm_pkg::RECIP120_SH);
        d6s   = neg3_4_reg ? -$signed({4'b0, d6_4_reg}) : $signed({4'b0, d6_4_reg});
        d120s = neg5_4_reg ? -$signed({7'b0, d120}) : $signed({7'b0, d120});
        acc   = 16'(xf4_reg) - d6s + d120s;
        if (acc > 16'(svpwm_pkg::Q_ONE)) begin
            acc = 16'(svpwm_pkg::Q_ONE);
        end
        if (acc < -16'(svpwm_pkg::Q_ONE)) begin
            acc = -16'(svpwm_pkg::Q_ONE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xf1_reg    <= xf;
            x2_1_reg   <= 14'(p2 >>> svpwm_pkg::FRAC_BITS);
            xf2_reg    <= xf1_reg;
            x2_2_reg   <= x2_1_reg;
            x3_2_reg   <= 16'(p3 >>> svpwm_pkg::FRAC_BITS);
            xf3_reg    <= xf2_reg;
            neg3_3_reg <= x3_2_reg[15];
            q6_3_reg   <= abs3 * 31'(svpwm_pkg::RECIP6);
            x5_3_reg   <= 17'(p5 >>> svpwm_pkg::FRAC_BITS);
            xf4_reg    <= xf3_reg;
            neg3_4_reg <= neg3_3_reg;
            neg5_4_reg <= x5_3_reg[16];
            d6_4_reg   <= 12'(q6_3_reg >> svpwm_pkg::RECIP6_SH);
            q120_4_reg <= abs5 * 32'(svpwm_pkg::RECIP120);
            s_reg      <= 14'(acc);
        end
    end

    assign s = s_reg;

endmodule

`default_nettype wire

>>> rtl/svpwm_isqrt.sv
// pipelined digit-by-digit square root, two result bits per stage, one in the last
`default_nettype none

module svpwm_isqrt (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [svpwm_pkg::SQ_W-1:0]         sq,
    output logic [svpwm_pkg::ROOT_W-1:0]       root
);

    localparam int VAL_W = svpwm_pkg::SQ_W + svpwm_pkg::FRAC_BITS;
    localparam int REM_W = svpwm_pkg::ROOT_W + 2;
    localparam int NSTEP = svpwm_pkg::ROOT_W;
    localparam int NSTG  = (NSTEP + 1) / 2;

    typedef struct packed {
        logic [REM_W-1:0]            rem;
        logic [svpwm_pkg::ROOT_W-1:0] root;
    } sqrt_acc_t;

    function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
        sqrt_acc_t        r;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        cur   = {a.rem[REM_W-3:0], pair};
        trial = {a.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {a.root[svpwm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {a.root[svpwm_pkg::ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    sqrt_acc_t        acc_reg [NSTG];
    logic [VAL_W-1:0] v_reg   [NSTG-1];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        sqrt_acc_t        acc_in;
        sqrt_acc_t        acc_mid;
        sqrt_acc_t        acc_next;
        logic [VAL_W-1:0] v_in;

        if (g == 0) begin : g_first
            assign acc_in = '0;
            assign v_in   = {sq, {svpwm_pkg::FRAC_BITS{1'b0}}};
        end else begin : g_rest
            assign acc_in = acc_reg[g-1];
            assign v_in   = v_reg[g-1];
        end

        always_comb begin
            acc_mid = sqrt_step(acc_in, v_in[VAL_W-1 -: 2]);
            if (2 * g + 1 < NSTEP) begin
                acc_next = sqrt_step(acc_mid, v_in[VAL_W-3 -: 2]);
            end else begin
                acc_next = acc_mid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[g] <= acc_next;
            end
        end

        if (g < NSTG - 1) begin : g_val
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[g] <= v_in << 4;
                end
            end
        end
    end

    assign root = acc_reg[NSTG-1].root;

endmodule

`default_nettype wire

>>> rtl/svpwm_div.sv
// pipelined magnitude over supply division, saturating at sqrt(3)/3
`default_nettype none

module svpwm_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [svpwm_pkg::ROOT_W-1:0]       mag,
    input  logic [svpwm_pkg::SUP_W-1:0]        supply,
    output logic [svpwm_pkg::UREF_W-1:0]       uref
);

    localparam int NSTG  = 4;
    localparam int STEPS = svpwm_pkg::UREF_W / NSTG;

    typedef struct packed {
        logic                           sat;
        logic [svpwm_pkg::SUP_W-1:0]    rem;
        logic [svpwm_pkg::UREF_W-1:0]   quo;
    } div_acc_t;

    div_acc_t acc_reg [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        div_acc_t                  acc_in;
        div_acc_t                  acc_next;
        logic [svpwm_pkg::SUP_W:0] cur;

        if (g == 0) begin : g_first
            // quotient reaches 2^FRAC_BITS exactly when mag >= supply
            always_comb begin
                acc_in.sat = (mag >= {1'b0, supply});
                acc_in.rem = mag[svpwm_pkg::SUP_W-1:0];
                acc_in.quo = '0;
            end
        end else begin : g_rest
            assign acc_in = acc_reg[g-1];
        end

        always_comb begin
            acc_next = acc_in;
            cur      = '0;
            for (int k = 0; k < STEPS; k++) begin
                cur = {acc_next.rem, 1'b0};
                if (cur >= {1'b0, supply}) begin
                    acc_next.rem = svpwm_pkg::SUP_W'(cur - {1'b0, supply});
                    acc_next.quo = {acc_next.quo[svpwm_pkg::UREF_W-2:0], 1'b1};
                end else begin
                    acc_next.rem = cur[svpwm_pkg::SUP_W-1:0];
                    acc_next.quo = {acc_next.quo[svpwm_pkg::UREF_W-2:0], 1'b0};
                end
            end
            if (g == NSTG - 1) begin
                if (acc_next.sat ||
                    acc_next.quo > svpwm_pkg::UREF_W'(svpwm_pkg::Q_SQRT3_DIV3)) begin
                    acc_next.quo = svpwm_pkg::UREF_W'(svpwm_pkg::Q_SQRT3_DIV3);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[g] <= acc_next;
            end
        end
    end

    assign uref = acc_reg[NSTG-1].quo;

endmodule

`default_nettype wire

>>> rtl/svpwm_duty_calculator.sv
// top level of the space-vector pwm duty calculator
//
// usage: one transaction on the s_ stream per pwm update carries volt_q,
// volt_d and elec_angle; one transaction on the m_ stream returns the three
// phase compare counts for it, in order. supply_voltage and the pwm period
// sit behind the apb port at byte addresses 0 and 4; the user must write them
// only while idle, and the block itself does not enforce it.
// throughput: one item per cycle while no stall holds the pipeline; the
// square root takes up to two digits and the division three steps per
// stage, and the 31 stages all advance together.
// stall: the whole pipeline holds while a result waits on m_tready, so
// s_tready follows !m_tvalid || m_tready and nothing is dropped or repeated.
// reset: aresetn low clears the valid bits and loads supply_voltage 49152
// and the period register 1000; no clearing pass is needed.
`default_nettype none

`include "svpwm_duty_calculator_macros.svh"

module svpwm_duty_calculator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // volt_q[17:0], volt_d[35:18], elec_angle[51:36], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // compare_a[15:0], compare_b[31:16], compare_c[47:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NPIPE = 31;
    localparam int OFS_S = 2 * svpwm_pkg::Q_2PI;
    localparam int OFS_P = 2 * svpwm_pkg::Q_2PI + svpwm_pkg::Q_PI_DIV2;
    localparam int OFS_M = 2 * svpwm_pkg::Q_2PI - svpwm_pkg::Q_PI_DIV2;

    logic [svpwm_pkg::SUP_W-1:0] supply_reg;
    logic [svpwm_pkg::PER_W-1:0] period_reg;
    logic                        en;
    logic                        vld_reg [NPIPE];

    // stage 1
    logic signed [17:0] uq1_reg, ud1_reg;
    logic signed [15:0] ang1_reg;
    // stage 2
    svpwm_pkg::angle_t  xs_n, xc_n, ar_n;
    svpwm_pkg::angle_t  xs2_reg, xc2_reg, ar2_reg;
    logic signed [17:0] uq2_reg, ud2_reg;
    // stage 3
    logic [2:0]         cnt;
    svpwm_pkg::angle_t  base, a1_n, a2_n;
    svpwm_pkg::angle_t  xs3_reg, xc3_reg, a1_3_reg, a2_3_reg;
    svpwm_pkg::sector_t sec3_reg;
    logic signed [17:0] uq3_reg, ud3_reg;
    // sine outputs, stage 8
    svpwm_pkg::sine_t   sn8, cs8, s1_8, s2_8;
    logic [35:0]        uqd_dly_reg [5];
    svpwm_pkg::sector_t sec_dly_reg [25];
    logic [27:0]        s12_dly_reg [18];
    logic signed [17:0] uq8, ud8;
    // rotation, stages 9..12
    logic signed [31:0] m_dc, m_qs, m_ds, m_qc;
    logic signed [18:0] pdc9_reg, pqs9_reg, pds9_reg, pqc9_reg;
    logic signed [19:0] ua10_reg, ub10_reg;
    logic signed [39:0] m_aa, m_bb;
    logic [24:0]        sa11_reg, sb11_reg;
    logic [svpwm_pkg::SQ_W-1:0]   sq12_reg;
    logic [svpwm_pkg::ROOT_W-1:0] mag22;
    logic [svpwm_pkg::UREF_W-1:0] uref26;
    // dwell times, stages 27..31
    svpwm_pkg::sine_t   s1_26, s2_26;
    logic signed [26:0] m_p1, m_p2;
    logic signed [13:0] p1_27_reg, p2_27_reg;
    logic signed [28:0] m_t1, m_t2;
    logic signed [15:0] t1_28_reg, t2_28_reg;
    svpwm_pkg::sector_t sec28;
    logic signed [15:0] t0, h0, h10, h20, ta_n, tb_n, tc_n;
    logic signed [15:0] ta29_reg, tb29_reg, tc29_reg;
    logic signed [32:0] pa30_reg, pb30_reg, pc30_reg;
    logic [15:0]        ca31_reg, cb31_reg, cc31_reg;
    logic               cmp_ok;
    logic               uref_ok;

    function automatic logic [15:0] to_compare(input logic signed [32:0] p,
                                               input logic [15:0] per);
        logic signed [20:0] c;
        c = 21'(p >>> svpwm_pkg::FRAC_BITS);
        if (c < 21'sd0) begin
            return 16'd0;
        end else if (c > $signed({5'b0, per})) begin
            return per;
        end
        return 16'(c);
    endfunction

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            svpwm_pkg::REG_SUPPLY: prdata = {14'b0, supply_reg};
            svpwm_pkg::REG_PERIOD: prdata = {16'b0, period_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            supply_reg <= svpwm_pkg::SUP_W'(svpwm_pkg::SUPPLY_RESET);
            period_reg <= svpwm_pkg::PER_W'(svpwm_pkg::PERIOD_RESET);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                svpwm_pkg::REG_SUPPLY: supply_reg <= pwdata[svpwm_pkg::SUP_W-1:0];
                svpwm_pkg::REG_PERIOD: period_reg <= pwdata[svpwm_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NPIPE-1];
    assign m_tdata  = {cc31_reg, cb31_reg, ca31_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NPIPE; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NPIPE; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // angle wrapping for sin, cos and the shifted vector angle
    always_comb begin
        xs_n = svpwm_pkg::wrap_angle(17'(18'(ang1_reg) + 18'(OFS_S)));
        xc_n = svpwm_pkg::wrap_angle(17'(18'(ang1_reg) + 18'(OFS_P)));
        if (uq1_reg > 18'sd0) begin
            ar_n = svpwm_pkg::wrap_angle(17'(18'(ang1_reg) + 18'(OFS_P)));
        end else begin
            ar_n = svpwm_pkg::wrap_angle(17'(18'(ang1_reg) + 18'(OFS_M)));
        end
    end

    // sector search and the two in-sector angles
    always_comb begin
        cnt = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (ar2_reg >= svpwm_pkg::ANG_W'(k * svpwm_pkg::Q_PI_DIV3)) begin
                cnt = cnt + 3'd1;
            end
        end
        base = svpwm_pkg::ANG_W'(int'(cnt) * svpwm_pkg::Q_PI_DIV3);
        a2_n = ar2_reg - base;
        a1_n = svpwm_pkg::ANG_W'(svpwm_pkg::Q_PI_DIV3) - a2_n;
    end

    svpwm_sin u_sin_s (.aclk(aclk), .en(en), .x(xs3_reg),  .s(sn8));
    svpwm_sin u_sin_c (.aclk(aclk), .en(en), .x(xc3_reg),  .s(cs8));
    svpwm_sin u_sin_1 (.aclk(aclk), .en(en), .x(a1_3_reg), .s(s1_8));
    svpwm_sin u_sin_2 (.aclk(aclk), .en(en), .x(a2_3_reg), .s(s2_8));

    assign uq8   = $signed(uqd_dly_reg[4][35:18]);
    assign ud8   = $signed(uqd_dly_reg[4][17:0]);
    assign sec28 = sec_dly_reg[24];
    assign s1_26 = $signed(s12_dly_reg[17][27:14]);
    assign s2_26 = $signed(s12_dly_reg[17][13:0]);

    // inverse park and squared magnitude
    always_comb begin
        m_dc = ud8 * cs8;
        m_qs = uq8 * sn8;
        m_ds = ud8 * sn8;
        m_qc = uq8 * cs8;
        m_aa = ua10_reg * ua10_reg;
        m_bb = ub10_reg * ub10_reg;
    end

    svpwm_isqrt u_isqrt (.aclk(aclk), .en(en), .sq(sq12_reg), .root(mag22));

    svpwm_div u_div (.aclk(aclk), .en(en), .mag(mag22), .supply(supply_reg),
                     .uref(uref26));

    // dwell times and per-phase half-times
    always_comb begin
        m_p1 = s1_26 * $signed({1'b0, uref26});
        m_p2 = s2_26 * $signed({1'b0, uref26});
        m_t1 = $signed(15'(svpwm_pkg::Q_SQRT3)) * p1_27_reg;
        m_t2 = $signed(15'(svpwm_pkg::Q_SQRT3)) * p2_27_reg;
    end

    always_comb begin
        t0  = 16'(svpwm_pkg::Q_ONE) - t1_28_reg - t2_28_reg;
        h0  = t0 >>> 1;
        h10 = 16'((17'(t1_28_reg) + 17'(t0)) >>> 1);
        h20 = 16'((17'(t2_28_reg) + 17'(t0)) >>> 1);
        case (sec28)
            svpwm_pkg::SECTOR_1: begin
                ta_n = 16'(svpwm_pkg::Q_HALF); tb_n = h20; tc_n = h0;
            end
            svpwm_pkg::SECTOR_2: begin
                ta_n = h10; tb_n = 16'(svpwm_pkg::Q_HALF); tc_n = h0;
            end
            svpwm_pkg::SECTOR_3: begin
                ta_n = h0; tb_n = 16'(svpwm_pkg::Q_HALF); tc_n = h20;
            end
            svpwm_pkg::SECTOR_4: begin
                ta_n = h0; tb_n = h10; tc_n = 16'(svpwm_pkg::Q_HALF);
            end
            svpwm_pkg::SECTOR_5: begin
                ta_n = h20; tb_n = h0; tc_n = 16'(svpwm_pkg::Q_HALF);
            end
            svpwm_pkg::SECTOR_6: begin
                ta_n = 16'(svpwm_pkg::Q_HALF); tb_n = h0; tc_n = h10;
            end
            // sliver just below 2pi lands here
            default: begin
                ta_n = '0; tb_n = '0; tc_n = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            uq1_reg  <= $signed(s_tdata[17:0]);
            ud1_reg  <= $signed(s_tdata[35:18]);
            ang1_reg <= $signed(s_tdata[51:36]);

            xs2_reg <= xs_n;
            xc2_reg <= xc_n;
            ar2_reg <= ar_n;
            uq2_reg <= uq1_reg;
            ud2_reg <= ud1_reg;

            xs3_reg  <= xs2_reg;
            xc3_reg  <= xc2_reg;
            a1_3_reg <= a1_n;
            a2_3_reg <= a2_n;
            sec3_reg <= svpwm_pkg::sector_t'(cnt + 3'd1);
            uq3_reg  <= uq2_reg;
            ud3_reg  <= ud2_reg;

            uqd_dly_reg[0] <= {uq3_reg, ud3_reg};
            for (int i = 1; i < 5; i++) begin
                uqd_dly_reg[i] <= uqd_dly_reg[i-1];
            end
            sec_dly_reg[0] <= sec3_reg;
            for (int i = 1; i < 25; i++) begin
                sec_dly_reg[i] <= sec_dly_reg[i-1];
            end
            s12_dly_reg[0] <= {s1_8, s2_8};
            for (int i = 1; i < 18; i++) begin
                s12_dly_reg[i] <= s12_dly_reg[i-1];
            end

            pdc9_reg <= 19'(m_dc >>> svpwm_pkg::FRAC_BITS);
            pqs9_reg <= 19'(m_qs >>> svpwm_pkg::FRAC_BITS);
            pds9_reg <= 19'(m_ds >>> svpwm_pkg::FRAC_BITS);
            pqc9_reg <= 19'(m_qc >>> svpwm_pkg::FRAC_BITS);

            ua10_reg <= 20'(pdc9_reg) - 20'(pqs9_reg);
            ub10_reg <= 20'(pds9_reg) + 20'(pqc9_reg);

            sa11_reg <= 25'(m_aa >>> svpwm_pkg::FRAC_BITS);
            sb11_reg <= 25'(m_bb >>> svpwm_pkg::FRAC_BITS);

            sq12_reg <= svpwm_pkg::SQ_W'(sa11_reg) + svpwm_pkg::SQ_W'(sb11_reg);

            p1_27_reg <= 14'(m_p1 >>> svpwm_pkg::FRAC_BITS);
            p2_27_reg <= 14'(m_p2 >>> svpwm_pkg::FRAC_BITS);

            t1_28_reg <= 16'(m_t1 >>> svpwm_pkg::FRAC_BITS);
            t2_28_reg <= 16'(m_t2 >>> svpwm_pkg::FRAC_BITS);

            ta29_reg <= ta_n;
            tb29_reg <= tb_n;
            tc29_reg <= tc_n;

            pa30_reg <= ta29_reg * $signed({1'b0, period_reg});
            pb30_reg <= tb29_reg * $signed({1'b0, period_reg});
            pc30_reg <= tc29_reg * $signed({1'b0, period_reg});

            ca31_reg <= to_compare(pa30_reg, period_reg);
            cb31_reg <= to_compare(pb30_reg, period_reg);
            cc31_reg <= to_compare(pc30_reg, period_reg);
        end
    end

    assign cmp_ok  = (m_tdata[15:0] <= period_reg) && (m_tdata[31:16] <= period_reg)
                     && (m_tdata[47:32] <= period_reg);
    assign uref_ok = !vld_reg[25] || (uref26 <= 12'(svpwm_pkg::Q_SQRT3_DIV3));

    `SVPWM_ASSERT_IMPL(a_cmp_le_period, aclk, aresetn, m_tvalid, cmp_ok)
    `SVPWM_ASSERT_ALWAYS(a_uref_clamped, aclk, aresetn, uref_ok)

endmodule

`default_nettype wire
